// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BBE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/bbe_pkg.sv -----
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types, constants and the reciprocal table of the edge-aware box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bbe_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int FW_W = 11;
    localparam int FH_W = 16;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 16'd768;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int LANES = 3;
    localparam int BANKS = 4;

    localparam int SUM_W = 12;
    localparam int CNT_W = 4;
    localparam int RECIP_W = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W = SUM_W + RECIP_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic acc;
        logic div;
    } t_merge_ctl;

    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/box_blur_3x3_edge_aware.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// Streaming 3x3 box blur of RGB pixels with in-frame neighbor counting.
// ----------------------------------------------------------------------------
// Each accepted item passes through the accept and release check states; an
// item that releases a result goes on to read the three neighborhood columns
// from the four row banks (one column per cycle, registered memory read), to
// a divide step and to the output load, which holds for as long as an earlier
// result still waits to be taken.
// Three row lanes work on one column at a time and a merge stage sums them
// and divides by the in-frame neighbor count. The result register lets the
// next item in while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire bbe_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output bbe_pkg::t_out_item               o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bbe_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bbe_pkg::APB_DW-1:0]  pwdata,
    output logic [bbe_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = CW + 1;
    localparam int FH = bbe_pkg::FH_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [bbe_pkg::FW_W-1:0] r_frame_width;
    logic [FH-1:0]            r_frame_height;
    logic                     w_cfg_we;

    logic [WW-1:0] w_w_eff, w_w_m1;
    logic [FH-1:0] w_h_eff, w_h_m1;

    logic [CW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [FH-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic          r_in_done, n_in_done;

    logic [2:0] r_state, n_state;
    logic [1:0] r_k;
    logic       r_col_ok;

    logic          w_accept, w_pix_we, w_load, w_frame_end;
    logic [WW-1:0] w_in_col_inc, w_out_col_inc;
    logic [FH:0]   w_in_row_inc, w_out_row_inc;
    logic [FH-1:0] w_tr;
    logic [CW-1:0] w_tc;
    logic          w_release;
    logic          w_up_ok, w_dn_ok, w_left_ok, w_right_ok;
    logic [CW-1:0] w_raddr;
    logic          w_col_ok;

    bbe_pkg::t_pix  w_wdata;
    bbe_pkg::t_pix  w_rdata [bbe_pkg::BANKS];
    bbe_pkg::t_pix  w_lane_pix [bbe_pkg::LANES];
    logic [bbe_pkg::LANES-1:0] w_lane_ok, w_row_ok;
    logic [1:0]     w_lane_sel [bbe_pkg::LANES];
    bbe_pkg::t_merge_ctl w_mctl;
    bbe_pkg::t_pix  w_mean;

    logic               r_out_valid;
    bbe_pkg::t_out_item r_out_item;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            bbe_pkg::CFG_HEIGHT: prdata = bbe_pkg::APB_DW'(r_frame_height);
            default:             prdata = bbe_pkg::APB_DW'(r_frame_width);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bbe_pkg::FW_RESET;
            r_frame_height <= bbe_pkg::FH_RESET;
        end else if (w_cfg_we) begin
            case (paddr[2])
                bbe_pkg::CFG_HEIGHT: r_frame_height <= pwdata[FH-1:0];
                default:             r_frame_width  <= pwdata[bbe_pkg::FW_W-1:0];
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (r_frame_width == '0) begin
            w_w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_w_eff = WW'(MAX_WIDTH);
        end else begin
            w_w_eff = WW'(r_frame_width);
        end
        w_h_eff = (r_frame_height == '0) ? FH'(1) : r_frame_height;
        w_w_m1  = w_w_eff - WW'(1);
        w_h_m1  = w_h_eff - FH'(1);
    end

    // position arithmetic
    always_comb begin
        w_in_col_inc  = {1'b0, r_in_col} + WW'(1);
        w_out_col_inc = {1'b0, r_out_col} + WW'(1);
        w_in_row_inc  = {1'b0, r_in_row} + (FH+1)'(1);
        w_out_row_inc = {1'b0, r_out_row} + (FH+1)'(1);

        w_up_ok    = (r_out_row != '0);
        w_dn_ok    = (w_out_row_inc < {1'b0, w_h_eff});
        w_left_ok  = (r_out_col != '0);
        w_right_ok = (w_out_col_inc < w_w_eff);

        w_tr = w_dn_ok ? w_out_row_inc[FH-1:0] : w_h_m1;
        w_tc = w_right_ok ? w_out_col_inc[CW-1:0] : w_w_m1[CW-1:0];
        w_release = r_in_done || (r_in_row > w_tr) ||
                    ((r_in_row == w_tr) && (r_in_col > w_tc));

        w_frame_end = !w_right_ok && !w_dn_ok;
    end

    // input side
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pix_we   = w_accept && (i_in_data.kind == bbe_pkg::KIND_PIXEL) && !r_in_done;

    assign w_wdata.red   = i_in_data.red_in;
    assign w_wdata.green = i_in_data.green_in;
    assign w_wdata.blue  = i_in_data.blue_in;

    // column read sequence
    always_comb begin
        case (r_k)
            2'd0: begin
                w_col_ok = w_left_ok;
                w_raddr  = w_left_ok ? (r_out_col - CW'(1)) : r_out_col;
            end
            2'd2: begin
                w_col_ok = w_right_ok;
                w_raddr  = w_right_ok ? w_out_col_inc[CW-1:0] : r_out_col;
            end
            default: begin
                w_col_ok = 1'b1;
                w_raddr  = r_out_col;
            end
        endcase
    end

    bbe_line_mem #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (w_pix_we),
        .i_wbank (r_in_row[1:0]),
        .i_waddr (r_in_col),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_row_ok = {w_dn_ok, 1'b1, w_up_ok};
    assign w_lane_sel[0] = r_out_row[1:0] - 2'd1;
    assign w_lane_sel[1] = r_out_row[1:0];
    assign w_lane_sel[2] = r_out_row[1:0] + 2'd1;

    for (genvar l = 0; l < bbe_pkg::LANES; l++) begin : g_lane
        bbe_lane u_lane (
            .i_bank (w_rdata),
            .i_sel  (w_lane_sel[l]),
            .i_ok   (w_row_ok[l] && r_col_ok),
            .o_pix  (w_lane_pix[l]),
            .o_ok   (w_lane_ok[l])
        );
    end

    always_comb begin
        w_mctl.clear = (r_state == S_CHECK);
        w_mctl.acc   = (r_state == S_READ) && (r_k != 2'd0);
        w_mctl.div   = (r_state == S_DIV);
    end

    bbe_merge u_merge (
        .i_clk      (i_clk),
        .i_ctl      (w_mctl),
        .i_lane_pix (w_lane_pix),
        .i_lane_ok  (w_lane_ok),
        .o_mean     (w_mean)
    );

    // sequencer
    assign w_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CHECK;
            S_CHECK: n_state = w_release ? S_READ : S_IDLE;
            S_READ:  if (r_k == 2'd3) n_state = S_DIV;
            S_DIV:   n_state = S_OUT;
            S_OUT:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_k <= r_k + 2'd1;
            end else begin
                r_k <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_ok <= w_col_ok;
    end

    // frame counters
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_done = r_in_done;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_cfg_we || (w_load && w_frame_end)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_in_done = 1'b0;
            n_out_col = '0;
            n_out_row = '0;
        end else begin
            if (w_pix_we) begin
                if (w_in_col_inc >= w_w_eff) begin
                    n_in_col = '0;
                    if (w_in_row_inc >= {1'b0, w_h_eff}) begin
                        n_in_row  = '0;
                        n_in_done = 1'b1;
                    end else begin
                        n_in_row = w_in_row_inc[FH-1:0];
                    end
                end else begin
                    n_in_col = w_in_col_inc[CW-1:0];
                end
            end
            if (w_load) begin
                if (!w_right_ok) begin
                    n_out_col = '0;
                    n_out_row = w_out_row_inc[FH-1:0];
                end else begin
                    n_out_col = w_out_col_inc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_done <= n_in_done;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item.red_out    <= w_mean.red;
            r_out_item.green_out  <= w_mean.green;
            r_out_item.blue_out   <= w_mean.blue;
            r_out_item.frame_last <= w_frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    `BBE_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, 1'b1, ({1'b0, r_in_col} < w_w_eff) && ({1'b0, r_out_col} < w_w_eff))
    `BBE_ASSERT_IMPL(a_out_lags_in, i_clk, i_rst_n, !r_in_done, (r_out_row < r_in_row) || ((r_out_row == r_in_row) && (r_out_col <= r_in_col)))
    `BBE_ASSERT_IMPL(a_load_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_OUT)
    `BBE_ASSERT_NEXT(a_hold_no_release, i_clk, i_rst_n, (r_state == S_CHECK) && !w_release && !w_cfg_we, $stable(r_out_row) && $stable(r_out_col) && !$rose(r_out_valid))

endmodule

`default_nettype wire

// ----- hw/rtl/bbe_line_mem.sv -----
// ----------------------------------------------------------------------------
// bbe_line_mem
// Four row banks, one write port and one registered read column for all banks.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_line_mem #(
    parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [1:0]    i_wbank,
    input  wire logic [CW-1:0] i_waddr,
    input  wire bbe_pkg::t_pix i_wdata,
    input  wire logic [CW-1:0] i_raddr,
    output bbe_pkg::t_pix      o_rdata [bbe_pkg::BANKS]
);

    for (genvar b = 0; b < bbe_pkg::BANKS; b++) begin : g_bank
        bbe_pkg::t_pix r_mem [MAX_WIDTH];
        bbe_pkg::t_pix r_rd;

        always_ff @(posedge i_clk) begin
            if (i_we && (i_wbank == 2'(b))) begin
                r_mem[i_waddr] <= i_wdata;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rd <= r_mem[i_raddr];
        end

        assign o_rdata[b] = r_rd;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bbe_lane.sv -----
// ----------------------------------------------------------------------------
// bbe_lane
// One neighborhood row: pick the row bank and mask pixels outside the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_lane (
    input  wire bbe_pkg::t_pix i_bank [bbe_pkg::BANKS],
    input  wire logic [1:0]    i_sel,
    input  wire logic          i_ok,
    output bbe_pkg::t_pix      o_pix,
    output logic               o_ok
);

    always_comb begin
        o_ok  = i_ok;
        o_pix = i_ok ? i_bank[i_sel] : '0;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bbe_merge.sv -----
// ----------------------------------------------------------------------------
// bbe_merge
// Sum lane pixels over three columns, then divide by the in-frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_merge (
    input  wire logic                        i_clk,
    input  wire bbe_pkg::t_merge_ctl         i_ctl,
    input  wire bbe_pkg::t_pix               i_lane_pix [bbe_pkg::LANES],
    input  wire logic [bbe_pkg::LANES-1:0]   i_lane_ok,
    output bbe_pkg::t_pix                    o_mean
);

    localparam int SW = bbe_pkg::SUM_W;
    localparam int PW = bbe_pkg::PROD_W;

    logic [SW-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [SW-1:0] n_sum_r, n_sum_g, n_sum_b;
    logic [bbe_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [bbe_pkg::RECIP_W-1:0] w_recip;
    logic [PW-1:0] w_prod_r, w_prod_g, w_prod_b;
    bbe_pkg::t_pix r_mean;

    always_comb begin
        n_sum_r = r_sum_r;
        n_sum_g = r_sum_g;
        n_sum_b = r_sum_b;
        n_cnt   = r_cnt;
        for (int l = 0; l < bbe_pkg::LANES; l++) begin
            n_sum_r = n_sum_r + SW'(i_lane_pix[l].red);
            n_sum_g = n_sum_g + SW'(i_lane_pix[l].green);
            n_sum_b = n_sum_b + SW'(i_lane_pix[l].blue);
            n_cnt   = n_cnt + bbe_pkg::CNT_W'(i_lane_ok[l]);
        end
    end

    always_comb begin
        w_recip  = bbe_pkg::f_recip(r_cnt);
        w_prod_r = PW'(r_sum_r) * PW'(w_recip);
        w_prod_g = PW'(r_sum_g) * PW'(w_recip);
        w_prod_b = PW'(r_sum_b) * PW'(w_recip);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
            r_cnt   <= '0;
        end else if (i_ctl.acc) begin
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
            r_cnt   <= n_cnt;
        end
        if (i_ctl.div) begin
            r_mean.red   <= w_prod_r[bbe_pkg::RECIP_SHIFT +: 8];
            r_mean.green <= w_prod_g[bbe_pkg::RECIP_SHIFT +: 8];
            r_mean.blue  <= w_prod_b[bbe_pkg::RECIP_SHIFT +: 8];
        end
    end

    assign o_mean = r_mean;

endmodule

`default_nettype wire

// ----- sim/tb_box_blur_3x3_edge_aware.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware
// Streams RGB frames of many sizes through the edge-aware 3x3 box blur and
// compares every released pixel with an in-bench line-memory predictor.
// Covers width/height clamping, drain ticks, stray pixels after frame end,
// frame restarts and register writes, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        in_valid;
    logic                        in_ready;
    bbe_pkg::t_in_item           in_data;
    logic                        out_valid;
    logic                        out_ready;
    bbe_pkg::t_out_item          out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bbe_pkg::APB_AW-1:0]  paddr;
    logic [bbe_pkg::APB_DW-1:0]  pwdata;
    logic [bbe_pkg::APB_DW-1:0]  prdata;
    logic                        pready;

    box_blur_3x3_edge_aware u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic [bbe_pkg::FW_W-1:0] cfg_w;
    logic [bbe_pkg::FH_W-1:0] cfg_h;
    logic [23:0]     row_mem [0:bbe_pkg::BANKS-1][0:bbe_pkg::MAX_WIDTH_DEF-1];
    int unsigned     in_col, in_row, out_col, out_row;
    bit              in_done;
    bbe_pkg::t_out_item blurred_expect [$];

    int  err_count;
    int  pix_items_sent;
    bit  idle_on;
    int  stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb_box_blur_3x3_edge_aware NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic int unsigned eff_w();
        if (cfg_w == 0) return 1;
        if (cfg_w > bbe_pkg::MAX_WIDTH_DEF) return bbe_pkg::MAX_WIDTH_DEF;
        return cfg_w;
    endfunction

    function automatic int unsigned eff_h();
        return (cfg_h == 0) ? 1 : cfg_h;
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        in_done = 1'b0;
    endfunction

    function automatic bit frame_open();
        return in_done || in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0;
    endfunction

    function automatic void blur_predict(input bbe_pkg::t_in_item it);
        int unsigned        w, h, tr, tc, sr, sg, sb, cnt;
        int                 r, c;
        bbe_pkg::t_pix      px;
        bbe_pkg::t_out_item res;
        w = eff_w();
        h = eff_h();
        if (it.kind == bbe_pkg::KIND_PIXEL && !in_done) begin
            row_mem[in_row % bbe_pkg::BANKS][in_col] = {it.red_in, it.green_in, it.blue_in};
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) begin
                    in_row  = 0;
                    in_done = 1'b1;
                end
            end
        end
        tr = (out_row + 1 < h) ? out_row + 1 : h - 1;
        tc = (out_col + 1 < w) ? out_col + 1 : w - 1;
        if (!(in_done || in_row > tr || (in_row == tr && in_col > tc))) return;
        sr  = 0;
        sg  = 0;
        sb  = 0;
        cnt = 0;
        for (r = int'(out_row) - 1; r <= int'(out_row) + 1; r++) begin
            for (c = int'(out_col) - 1; c <= int'(out_col) + 1; c++) begin
                if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w)) begin
                    px = row_mem[r % bbe_pkg::BANKS][c];
                    sr += px.red;
                    sg += px.green;
                    sb += px.blue;
                    cnt++;
                end
            end
        end
        if (cnt == 0) cnt = 1;
        res.red_out    = 8'(sr / cnt);
        res.green_out  = 8'(sg / cnt);
        res.blue_out   = 8'(sb / cnt);
        res.frame_last = 1'b0;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) begin
                res.frame_last = 1'b1;
                restart_frame();
            end
        end
        blurred_expect.push_back(res);
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one transfer on the pixel channel; valid is left high for a following call
    task automatic send_item(input logic kind, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        bbe_pkg::t_in_item it;
        it.kind     = kind;
        it.red_in   = r;
        it.green_in = g;
        it.blue_in  = b;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        blur_predict(it);
        pix_items_sent++;
    endtask

    task automatic send_pixel();
        send_item(bbe_pkg::KIND_PIXEL, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic send_drain();
        send_item(bbe_pkg::KIND_DRAIN, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (blurred_expect.size() == 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        logic [31:0] mask;
        mask = (idx == bbe_pkg::CFG_WIDTH) ? 32'h0000_07FF : 32'h0000_FFFF;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == bbe_pkg::CFG_WIDTH) cfg_w = bbe_pkg::FW_W'(val & mask);
        else                           cfg_h = bbe_pkg::FH_W'(val & mask);
        restart_frame();
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (val & mask))
            report_mismatch(idx == bbe_pkg::CFG_WIDTH ? "frame_width readback"
                                                      : "frame_height readback",
                            prdata, val & mask);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_frame(input int w, input int h);
        settle();
        cfg_write(bbe_pkg::CFG_WIDTH, w);
        cfg_write(bbe_pkg::CFG_HEIGHT, h);
    endtask

    // drain remaining outputs, with the odd stray pixel that must be dropped
    task automatic finish_frame();
        while (frame_open()) begin
            if ($urandom_range(0, 5) == 0) send_pixel();
            else                           send_drain();
        end
    endtask

    task automatic run_frame(input int abort_at);
        int n;
        n = (abort_at < 0) ? int'(eff_w() * eff_h()) : abort_at;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) send_drain();
            send_pixel();
        end
        if (abort_at < 0) finish_frame();
    endtask

    task automatic test_early_steps();
        send_drain();
        repeat (6) send_pixel();
        send_drain();
    endtask

    task automatic test_extreme_values();
        set_frame(3, 3);
        for (int i = 0; i < 9; i++) begin
            if (i % 2 == 0) send_item(bbe_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
            else            send_item(bbe_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        end
        send_item(bbe_pkg::KIND_PIXEL, 8'hA5, 8'h5A, 8'h3C);
        while (frame_open()) send_drain();
        send_drain();
    endtask

    task automatic test_width_extremes();
        set_frame(0, 0);
        run_frame(-1);
        set_frame(1, 5);
        run_frame(-1);
        set_frame(2047, 1);
        run_frame(20);
        set_frame(1030, 1);
        run_frame(30);
    endtask

    task automatic test_height_extremes();
        set_frame(1, 65535);
        run_frame(10);
        set_frame(5, 0);
        run_frame(-1);
        run_frame(-1);
    endtask

    task automatic test_random_frames(input int target);
        int start, w, h, frames, total, abort_at;
        start = pix_items_sent;
        while (pix_items_sent - start < target) begin
            case ($urandom_range(0, 9))
                0, 1:    w = $urandom_range(9, 24);
                2:       w = $urandom_range(0, 1);
                default: w = $urandom_range(1, 8);
            endcase
            h = ($urandom_range(0, 19) == 0) ? 65535 : $urandom_range(0, 6);
            set_frame(w, h);
            frames = (h == 65535) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if (pix_items_sent - start >= target) break;
                total    = eff_w() * eff_h();
                abort_at = -1;
                if (h == 65535 || (f == frames - 1 && $urandom_range(0, 7) == 0))
                    abort_at = $urandom_range(0, (total < 60) ? total - 1 : 60);
                run_frame(abort_at);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        bbe_pkg::t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (blurred_expect.size() == 0) begin
                report_mismatch("unexpected output transfer", 1, 0);
            end else begin
                want = blurred_expect.pop_front();
                if (out_data.red_out !== want.red_out)
                    report_mismatch("red_out", out_data.red_out, want.red_out);
                if (out_data.green_out !== want.green_out)
                    report_mismatch("green_out", out_data.green_out, want.green_out);
                if (out_data.blue_out !== want.blue_out)
                    report_mismatch("blue_out", out_data.blue_out, want.blue_out);
                if (out_data.frame_last !== want.frame_last)
                    report_mismatch("frame_last", out_data.frame_last, want.frame_last);
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        err_count      = 0;
        pix_items_sent = 0;
        idle_on        = 1'b1;
        cfg_w          = bbe_pkg::FW_RESET;
        cfg_h          = bbe_pkg::FH_RESET;
        restart_frame();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_early_steps();
        test_extreme_values();
        test_width_extremes();
        test_height_extremes();
        test_random_frames(650);
        idle_on = 1'b0;
        test_random_frames(60);

        settle();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_box_blur_3x3_edge_aware OK");
        end else begin
            $display("tb_box_blur_3x3_edge_aware NOT OK");
        end
        $finish;
    end

endmodule
